// ===== rtl/sfdpl_pkg.sv =====
// ---------------------------------------------------------------------------
// sfdpl_pkg: shared types and constants
// Types, fixed-point constants and the saturation helper used by the
// stereo feedback delay with triangle pan LFO.
// ---------------------------------------------------------------------------
package sfdpl_pkg;

  // Wide accumulator for the output mix (Q4.22 gain x Q1.15 level x Q1.15 sample)
  localparam int ACC_W = 59;
  // Pan gains, Q4.22, wide enough for two minus the right gain
  localparam int PAN_W = 26;

  localparam logic [15:0] Q15_ONE      = 16'd32768;
  localparam logic [22:0] DEPTH_MAX    = 23'd4194304;
  localparam int          UNITY_GAIN   = 4194304;
  localparam int          GAIN_MAX     = 8388607;
  localparam int          GAIN_MIN     = -8388608;

  localparam logic signed [ACC_W-1:0] SAT_HI = 32767;
  localparam logic signed [ACC_W-1:0] SAT_LO = -32768;

  // Configuration register indexes
  localparam logic [2:0] REG_DELAY_LENGTH  = 3'd0;
  localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [2:0] REG_WET_LEVEL     = 3'd2;
  localparam logic [2:0] REG_PAN_STEP      = 3'd3;
  localparam logic [2:0] REG_PAN_DEPTH     = 3'd4;
  localparam logic [2:0] REG_ADD_TO_OUTPUT = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_SUM
  } state_t;

  // Stage enables for one channel lane
  typedef struct packed {
    logic load;
    logic mul;
    logic mix;
  } lane_ctrl_t;

  // Clip a wide signed value to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7fff;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sfdpl_ram.sv =====
// ---------------------------------------------------------------------------
// sfdpl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sfdpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sfdpl_lane.sv =====
// ---------------------------------------------------------------------------
// sfdpl_lane: one channel of the delay datapath
// Feedback write-back value and the wet/dry/prior output mix for one channel.
// ---------------------------------------------------------------------------
module sfdpl_lane (
  input  logic                                clk,
  input  sfdpl_pkg::lane_ctrl_t               ctrl,
  input  logic signed [15:0]                  sample,
  input  logic signed [15:0]                  prior,
  input  logic signed [15:0]                  stored,
  input  logic signed [16:0]                  fb,
  input  logic signed [16:0]                  wet,
  input  logic signed [16:0]                  dry,
  input  logic signed [sfdpl_pkg::PAN_W-1:0]  gain,
  input  logic                                add_mode,
  output logic signed [15:0]                  store_value,
  output logic signed [15:0]                  result
);

  localparam int AW = sfdpl_pkg::ACC_W;
  localparam logic signed [AW-1:0] RND_OUT = {{(AW-37){1'b0}}, 1'b1, 36'b0};
  localparam logic signed [32:0]   RND_FB  = 33'sd16384;

  logic signed [15:0]   smp;
  logic signed [15:0]   pri;
  logic signed [32:0]   fbprod;
  logic signed [32:0]   wd;
  logic signed [32:0]   dryprod;
  logic signed [AW-1:0] gp;
  logic signed [AW-1:0] base;

  logic signed [32:0]   fb_rnd;
  logic signed [AW-1:0] fb_ext;
  logic signed [AW-1:0] smp_ext;
  logic signed [AW-1:0] dry_ext;
  logic signed [AW-1:0] pri_ext;
  logic signed [AW-1:0] pri_term;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_rnd;

  // Hold the beat, then multiply, then scale by gain and gather the dry part
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      smp <= sample;
      pri <= prior;
    end
    if (ctrl.mul) begin
      fbprod  <= 33'(stored) * 33'(fb);
      wd      <= 33'(stored) * 33'(wet);
      dryprod <= 33'(smp) * 33'(dry);
    end
    if (ctrl.mix) begin
      gp   <= wd * gain;
      base <= (dry_ext <<< 22) + pri_term;
    end
  end

  // Round the feedback product, add the new sample and clip
  always_comb begin
    fb_rnd      = (fbprod + RND_FB) >>> 15;
    fb_ext      = AW'(fb_rnd);
    smp_ext     = AW'(smp);
    store_value = sfdpl_pkg::sat16(fb_ext + smp_ext);
  end

  // Dry part widened; prior value aligned to the accumulator scale in add mode, else zero
  always_comb begin
    dry_ext  = AW'(dryprod);
    pri_ext  = AW'(pri);
    pri_term = add_mode ? (pri_ext <<< 37) : '0;
  end

  // Final sum, round to nearest and clip
  always_comb begin
    acc     = gp + base;
    acc_rnd = (acc + RND_OUT) >>> 37;
    result  = sfdpl_pkg::sat16(acc_rnd);
  end

endmodule

// ===== rtl/sfdpl_pan.sv =====
// ---------------------------------------------------------------------------
// sfdpl_pan: triangle pan LFO
// Steps the right gain up or down and turns when it leaves unity +/- depth;
// the left gain is two minus the right gain.
// ---------------------------------------------------------------------------
module sfdpl_pan (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic [15:0]                        step,
  input  logic [22:0]                        depth,
  output logic signed [sfdpl_pkg::PAN_W-1:0] gain_right,
  output logic signed [sfdpl_pkg::PAN_W-1:0] gain_left
);

  localparam int PW = sfdpl_pkg::PAN_W;
  localparam logic signed [PW-1:0] UNITY = PW'(sfdpl_pkg::UNITY_GAIN);
  localparam logic signed [PW-1:0] G_MAX = PW'(sfdpl_pkg::GAIN_MAX);
  localparam logic signed [PW-1:0] G_MIN = PW'(sfdpl_pkg::GAIN_MIN);

  logic signed [23:0]   rg;
  logic                 falling;

  logic signed [PW-1:0] rg_ext;
  logic signed [PW-1:0] step_s;
  logic signed [PW-1:0] depth_s;
  logic signed [PW-1:0] nxt;
  logic signed [PW-1:0] nxt_sat;
  logic                 turn;

  // Next gain, clipped to 24 bits, and the turn test against the swing bounds
  always_comb begin
    rg_ext  = PW'(rg);
    step_s  = {{(PW-16){1'b0}}, step};
    depth_s = {{(PW-23){1'b0}}, depth};
    nxt     = falling ? rg_ext - step_s : rg_ext + step_s;
    if (nxt > G_MAX) begin
      nxt_sat = G_MAX;
    end else if (nxt < G_MIN) begin
      nxt_sat = G_MIN;
    end else begin
      nxt_sat = nxt;
    end
    turn = (nxt_sat > UNITY + depth_s) || (nxt_sat < UNITY - depth_s);
  end

  // Advance once per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      rg      <= 24'(sfdpl_pkg::UNITY_GAIN);
      falling <= 1'b0;
    end else if (advance) begin
      rg      <= nxt_sat[23:0];
      falling <= falling ^ turn;
    end
  end

  assign gain_right = rg_ext;
  assign gain_left  = (UNITY <<< 1) - rg_ext;

endmodule

// ===== rtl/stereo_feedback_delay_pan_lfo_top.sv =====
// ---------------------------------------------------------------------------
// stereo_feedback_delay_pan_lfo_top: stereo feedback delay with pan LFO
// Shared circular delay memory (left and right in one word), per-channel
// mix lanes and a triangle pan LFO, run by a short sequencer.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    left_in, right_in, left_prior, right_prior
//  output    out_valid / out_ready  left_out, right_out
//  config    cfg_en (no wait)       cfg_index, cfg_data
//
//  Each stereo beat runs through the steps accept and memory read, multiply,
//  gain scale with write-back, final sum into the output register.
//  Beats do not overlap in the read-modify-write of the one delay memory.
//  After reset a clearing pass zeroes every memory word with in_ready low;
//  configuration writes are taken during it.
//  A full output register stalls the sum step until the beat is taken;
//  the next input beat is accepted while a result waits.
// ---------------------------------------------------------------------------
module stereo_feedback_delay_pan_lfo_top #(
  parameter int DELAY_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic signed [15:0] left_prior,
  input  logic signed [15:0] right_prior,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  input  logic               cfg_en,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int LW = (AW + 1 > 17) ? AW + 1 : 17;
  localparam logic [AW-1:0] CLR_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [LW-1:0] LEN_MAX  = LW'(DELAY_DEPTH);

  // Configuration registers
  logic [16:0] delay_length;
  logic [15:0] feedback_gain;
  logic [15:0] wet_level;
  logic [15:0] pan_step;
  logic [22:0] pan_depth;
  logic        add_to_output;

  sfdpl_pkg::state_t     state;
  sfdpl_pkg::state_t     state_next;
  sfdpl_pkg::lane_ctrl_t lane_ctrl;

  logic [AW-1:0] pos;
  logic [AW-1:0] clr_cnt;
  logic [LW-1:0] len_c;
  logic [LW-1:0] pos_inc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic [15:0]        fb_c;
  logic [15:0]        wet_c;
  logic [22:0]        depth_c;
  logic signed [16:0] fb_q;
  logic signed [16:0] wet_q;
  logic signed [16:0] dry_q;

  logic signed [sfdpl_pkg::PAN_W-1:0] gain_r;
  logic signed [sfdpl_pkg::PAN_W-1:0] gain_l;

  logic signed [15:0] l_store;
  logic signed [15:0] r_store;
  logic signed [15:0] l_res;
  logic signed [15:0] r_res;
  logic               out_load;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= 17'd48000;
      feedback_gain <= '0;
      wet_level     <= '0;
      pan_step      <= 16'd175;
      pan_depth     <= '0;
      add_to_output <= 1'b0;
    end else if (cfg_en) begin
      case (cfg_index)
        sfdpl_pkg::REG_DELAY_LENGTH:  delay_length  <= cfg_data[16:0];
        sfdpl_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[15:0];
        sfdpl_pkg::REG_WET_LEVEL:     wet_level     <= cfg_data[15:0];
        sfdpl_pkg::REG_PAN_STEP:      pan_step      <= cfg_data[15:0];
        sfdpl_pkg::REG_PAN_DEPTH:     pan_depth     <= cfg_data;
        sfdpl_pkg::REG_ADD_TO_OUTPUT: add_to_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp levels and depth to unity, derive the dry level
  always_comb begin
    fb_c    = (feedback_gain > sfdpl_pkg::Q15_ONE) ? sfdpl_pkg::Q15_ONE : feedback_gain;
    wet_c   = (wet_level > sfdpl_pkg::Q15_ONE) ? sfdpl_pkg::Q15_ONE : wet_level;
    depth_c = (pan_depth > sfdpl_pkg::DEPTH_MAX) ? sfdpl_pkg::DEPTH_MAX : pan_depth;
    fb_q    = {1'b0, fb_c};
    wet_q   = {1'b0, wet_c};
    dry_q   = {1'b0, sfdpl_pkg::Q15_ONE} - wet_q;
  end

  // Effective delay length and the next position
  always_comb begin
    len_c = LW'(delay_length);
    if (len_c == '0) begin
      len_c = LW'(1);
    end else if (len_c > LEN_MAX) begin
      len_c = LEN_MAX;
    end
    pos_inc = LW'(pos) + LW'(1);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfdpl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and stage controls
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    lane_ctrl.load = 1'b0;
    lane_ctrl.mul  = 1'b0;
    lane_ctrl.mix  = 1'b0;
    ram_we         = 1'b0;
    out_load       = 1'b0;
    case (state)
      sfdpl_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt == CLR_LAST) begin
          state_next = sfdpl_pkg::ST_IDLE;
        end
      end
      sfdpl_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        lane_ctrl.load = in_valid;
        if (in_valid) begin
          state_next = sfdpl_pkg::ST_MUL;
        end
      end
      sfdpl_pkg::ST_MUL: begin
        lane_ctrl.mul = 1'b1;
        state_next    = sfdpl_pkg::ST_MIX;
      end
      sfdpl_pkg::ST_MIX: begin
        lane_ctrl.mix = 1'b1;
        ram_we        = 1'b1;
        state_next    = sfdpl_pkg::ST_SUM;
      end
      sfdpl_pkg::ST_SUM: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = sfdpl_pkg::ST_IDLE;
        end
      end
      default: state_next = sfdpl_pkg::ST_IDLE;
    endcase
  end

  // Advance the clearing sweep and the store position
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pos     <= '0;
    end else begin
      if (state == sfdpl_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == sfdpl_pkg::ST_MIX) begin
        pos <= (pos_inc >= len_c) ? '0 : pos_inc[AW-1:0];
      end
    end
  end

  // Memory port selection: zero during the sweep, write-back otherwise
  always_comb begin
    if (state == sfdpl_pkg::ST_CLEAR) begin
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_waddr = pos;
      ram_wdata = {l_store, r_store};
    end
  end

  sfdpl_ram #(
    .WIDTH (32),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  sfdpl_pan u_pan (
    .clk        (clk),
    .rst        (rst),
    .advance    (state == sfdpl_pkg::ST_MIX),
    .step       (pan_step),
    .depth      (depth_c),
    .gain_right (gain_r),
    .gain_left  (gain_l)
  );

  sfdpl_lane u_left (
    .clk         (clk),
    .ctrl        (lane_ctrl),
    .sample      (left_in),
    .prior       (left_prior),
    .stored      (ram_rdata[31:16]),
    .fb          (fb_q),
    .wet         (wet_q),
    .dry         (dry_q),
    .gain        (gain_l),
    .add_mode    (add_to_output),
    .store_value (l_store),
    .result      (l_res)
  );

  sfdpl_lane u_right (
    .clk         (clk),
    .ctrl        (lane_ctrl),
    .sample      (right_in),
    .prior       (right_prior),
    .stored      (ram_rdata[15:0]),
    .fb          (fb_q),
    .wet         (wet_q),
    .dry         (dry_q),
    .gain        (gain_r),
    .add_mode    (add_to_output),
    .store_value (r_store),
    .result      (r_res)
  );

  // Output register: load a finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= l_res;
      right_out <= r_res;
    end
  end

  // An accepted beat always moves straight on to the multiply step
  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == sfdpl_pkg::ST_MUL)
    else $error("accepted beat did not enter the multiply step");

  // Memory writes only during the sweep or the write-back step
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == sfdpl_pkg::ST_CLEAR || state == sfdpl_pkg::ST_MIX))
    else $error("memory written outside sweep or write-back");

  // After an advance the position lies inside the delay length
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    state == sfdpl_pkg::ST_MIX |=> LW'(pos) < len_c)
    else $error("store position beyond delay length");

endmodule
